// ===== hw/rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, codes and helpers for the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_MATCH  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_DUP       = 2'd3;

	localparam logic [1:0] OP_NOP = 2'd0;
	localparam logic [1:0] OP_INS = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;
	localparam logic [1:0] OP_SET = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [31:0] id;
		logic [31:0] price;
		logic [31:0] rem;
		logic [31:0] arrival;
	} order_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] qty;
		order_t      ord;
	} chain_ctl_t;

	// Serial-number order on arrival stamps.
	function automatic logic arrived_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return (d != 32'd0) && !d[31];
	endfunction

	// True when order n ranks ahead of resting entry c on its side.
	function automatic logic ranks_ahead(input logic is_bid, input order_t n,
			input order_t c);
		logic better;
		better = is_bid ? (n.price > c.price) : (n.price < c.price);
		if (!c.valid)
			return 1'b1;
		if (n.price != c.price)
			return better;
		return arrived_before(n.arrival, c.arrival);
	endfunction

endpackage

// ===== hw/rtl/lobm_cell.sv =====
// ----------------------------------------------------------------------------
// lobm_cell
// One place of a sorted order chain; trades entries with its neighbors.
// ----------------------------------------------------------------------------
module lobm_cell #(
	parameter int IW     = 6,
	parameter int POS    = 0,
	parameter bit IS_BID = 1'b1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lobm_pkg::chain_ctl_t ctl,
	input  logic [IW-1:0]       idx,
	input  lobm_pkg::order_t    left,
	input  logic                left_ok,
	input  lobm_pkg::order_t    right,
	output lobm_pkg::order_t    entry,
	output logic                hit
);
	import lobm_pkg::*;

	logic        valid_q;
	logic [31:0] id_q;
	logic [31:0] price_q;
	logic [31:0] rem_q;
	logic [31:0] arrival_q;
	order_t      cur;
	order_t      nxt;
	logic        here;
	logic        prev;

	assign cur  = '{valid_q, id_q, price_q, rem_q, arrival_q};
	assign here = ranks_ahead(IS_BID, ctl.ord, cur);
	assign prev = left_ok && ranks_ahead(IS_BID, ctl.ord, left);
	assign hit  = cur.valid && (cur.id == ctl.ord.id);
	assign entry = cur;

	always_comb begin
		nxt = cur;
		case (ctl.op)
			OP_INS: begin
				if (prev)
					nxt = left;
				else if (here)
					nxt = ctl.ord;
			end
			OP_DEL: begin
				if (IW'(POS) >= idx)
					nxt = right;
			end
			OP_SET: begin
				if (IW'(POS) == idx)
					nxt.rem = ctl.qty;
			end
			default: nxt = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= nxt.valid;
	end

	always_ff @(posedge clk) begin
		id_q      <= nxt.id;
		price_q   <= nxt.price;
		rem_q     <= nxt.rem;
		arrival_q <= nxt.arrival;
	end

endmodule

// ===== hw/rtl/lobm_chain.sv =====
// ----------------------------------------------------------------------------
// lobm_chain
// A row of cells holding one side of the book, best order at place zero.
// ----------------------------------------------------------------------------
module lobm_chain #(
	parameter int N      = 64,
	parameter int IW     = 6,
	parameter bit IS_BID = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lobm_pkg::chain_ctl_t ctl,
	input  logic [IW-1:0]        idx,
	output lobm_pkg::order_t     head,
	output logic [N-1:0]         hits
);
	import lobm_pkg::*;

	order_t ent [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		order_t l;
		order_t r;
		assign l = (i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1];
		assign r = (i == N - 1) ? '0 : ent[(i == N - 1) ? i : i + 1];
		lobm_cell #(.IW(IW), .POS(i), .IS_BID(IS_BID)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.idx     (idx),
			.left    (l),
			.left_ok (i != 0),
			.right   (r),
			.entry   (ent[i]),
			.hit     (hits[i])
		);
	end

	assign head = ent[0];

endmodule

// ===== hw/rtl/limit_order_book_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority order book built from two sorted cell chains.
// ----------------------------------------------------------------------------
// Add, cancel and modify pass through lookup, apply and result from the input
// beat to the result beat; a new input beat is taken only after the result
// beat, so the next command waits until the last one is done. Matching takes
// lookup and apply, one match step per trade plus one to see the settled book,
// then buffer read and show per trade beat. A stalled result beat holds everything.
// Reset empties every chain place, and clears the order count and arrival stamp.
module limit_order_book_matcher_unit #(
	parameter int MAX_ORDERS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  command,
	input  logic [31:0] order_id,
	input  logic        is_buy,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        kind,
	output logic [1:0]  status,
	output logic [31:0] bid_order_id,
	output logic [31:0] ask_order_id,
	output logic [31:0] trade_price,
	output logic [31:0] trade_quantity,
	output logic [31:0] best_bid,
	output logic [31:0] best_ask,
	output logic [6:0]  resting_count,
	output logic        last
);
	import lobm_pkg::*;

	localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_APPLY = 3'd2;
	localparam logic [2:0] S_MATCH = 3'd3;
	localparam logic [2:0] S_STAT  = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;
	localparam logic [2:0] S_SHOW  = 3'd6;

	typedef struct packed {
		logic [31:0] bid_id;
		logic [31:0] ask_id;
		logic [31:0] px;
		logic [31:0] qty;
	} trade_t;

	logic [2:0]  state_q;
	logic [1:0]  cmd_q;
	logic [31:0] id_q;
	logic        buy_q;
	logic [31:0] px_q;
	logic [31:0] qty_q;
	logic [1:0]  status_q;
	logic [6:0]  count_q;
	logic [31:0] arrival_q;
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic        any_trade_q;

	logic [MAX_ORDERS-1:0] hits_b;
	logic [MAX_ORDERS-1:0] hits_a;
	logic [MAX_ORDERS-1:0] hit_b_q;
	logic [MAX_ORDERS-1:0] hit_a_q;
	logic [IW-1:0] pos_b;
	logic [IW-1:0] pos_a;

	order_t     head_b;
	order_t     head_a;
	chain_ctl_t ctl_b;
	chain_ctl_t ctl_a;
	logic [IW-1:0] idx_b;
	logic [IW-1:0] idx_a;

	trade_t trade_mem [MAX_ORDERS];
	trade_t rd_q;
	trade_t wr_data;

	logic        accept;
	logic        crossed;
	logic [31:0] fill;
	logic        pop_b;
	logic        pop_a;
	logic        found_b;
	logic        found_a;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);

	// Place of the single hit on each side, from the registered lookup.
	always_comb begin
		pos_b = '0;
		pos_a = '0;
		for (int i = 0; i < MAX_ORDERS; i++) begin
			if (hit_b_q[i])
				pos_b = pos_b | IW'(i);
			if (hit_a_q[i])
				pos_a = pos_a | IW'(i);
		end
	end

	assign found_b = |hit_b_q;
	assign found_a = |hit_a_q;

	// A match step pairs the two chain heads when their prices cross.
	assign crossed = head_b.valid && head_a.valid && (head_b.price >= head_a.price);
	assign fill    = (head_b.rem < head_a.rem) ? head_b.rem : head_a.rem;
	assign pop_b   = (head_b.rem == fill);
	assign pop_a   = (head_a.rem == fill);

	assign wr_data.bid_id = head_b.id;
	assign wr_data.ask_id = head_a.id;
	assign wr_data.px     = head_a.price;
	assign wr_data.qty    = fill;

	// Chain commands. The lookup id travels in the order slot in every cycle.
	always_comb begin
		ctl_b = '0;
		ctl_a = '0;
		ctl_b.ord.id = id_q;
		ctl_a.ord.id = id_q;
		idx_b = '0;
		idx_a = '0;
		case (state_q)
			S_APPLY: begin
				case (cmd_q)
					CMD_ADD: begin
						if (!found_b && !found_a && (count_q != 7'(MAX_ORDERS))) begin
							ctl_b.ord.valid   = 1'b1;
							ctl_b.ord.price   = px_q;
							ctl_b.ord.rem     = qty_q;
							ctl_b.ord.arrival = arrival_q;
							ctl_a.ord         = ctl_b.ord;
							ctl_b.op = buy_q ? OP_INS : OP_NOP;
							ctl_a.op = buy_q ? OP_NOP : OP_INS;
						end
					end
					CMD_CANCEL, CMD_MODIFY: begin
						ctl_b.qty = qty_q;
						ctl_a.qty = qty_q;
						idx_b = pos_b;
						idx_a = pos_a;
						if (found_b)
							ctl_b.op = (cmd_q == CMD_CANCEL || qty_q == 32'd0) ? OP_DEL : OP_SET;
						if (found_a)
							ctl_a.op = (cmd_q == CMD_CANCEL || qty_q == 32'd0) ? OP_DEL : OP_SET;
					end
					default: begin
						ctl_b.op = OP_NOP;
					end
				endcase
			end
			S_MATCH: begin
				if (crossed) begin
					ctl_b.op  = pop_b ? OP_DEL : OP_SET;
					ctl_a.op  = pop_a ? OP_DEL : OP_SET;
					ctl_b.qty = head_b.rem - fill;
					ctl_a.qty = head_a.rem - fill;
				end
			end
			default: begin
				ctl_b.op = OP_NOP;
			end
		endcase
	end

	lobm_chain #(.N(MAX_ORDERS), .IW(IW), .IS_BID(1'b1)) u_bids (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_b),
		.idx    (idx_b),
		.head   (head_b),
		.hits   (hits_b)
	);

	lobm_chain #(.N(MAX_ORDERS), .IW(IW), .IS_BID(1'b0)) u_asks (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_a),
		.idx    (idx_a),
		.head   (head_a),
		.hits   (hits_a)
	);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			arrival_q   <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			any_trade_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					status_q <= ST_OK;
					state_q  <= S_STAT;
					case (cmd_q)
						CMD_ADD: begin
							if (found_b || found_a) begin
								status_q <= ST_DUP;
							end else if (count_q == 7'(MAX_ORDERS)) begin
								status_q <= ST_FULL;
							end else begin
								count_q   <= count_q + 7'd1;
								arrival_q <= arrival_q + 32'd1;
							end
						end
						CMD_CANCEL, CMD_MODIFY: begin
							if (!found_b && !found_a)
								status_q <= ST_NOT_FOUND;
							else if (cmd_q == CMD_CANCEL || qty_q == 32'd0)
								count_q <= count_q - 7'd1;
						end
						default: begin
							state_q     <= S_MATCH;
							wr_ptr_q    <= '0;
							any_trade_q <= 1'b0;
						end
					endcase
				end
				S_MATCH: begin
					if (crossed) begin
						wr_ptr_q    <= wr_ptr_q + IW'(1);
						any_trade_q <= 1'b1;
						count_q     <= count_q - 7'(pop_b) - 7'(pop_a);
					end else if (any_trade_q) begin
						rd_ptr_q <= '0;
						state_q  <= S_RD;
					end else begin
						state_q <= S_STAT;
					end
				end
				S_STAT: begin
					if (!res_stall)
						state_q <= S_IDLE;
				end
				S_RD: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (!res_stall) begin
						rd_ptr_q <= rd_ptr_q + IW'(1);
						state_q  <= last ? S_IDLE : S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input beat and lookup results.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			id_q  <= order_id;
			buy_q <= is_buy;
			px_q  <= price;
			qty_q <= quantity;
		end
		hit_b_q <= hits_b;
		hit_a_q <= hits_a;
	end

	// Trade buffer: trades are held until the book has settled, since every
	// result beat reports the book after the whole match.
	always_ff @(posedge clk) begin
		if (state_q == S_MATCH && crossed)
			trade_mem[wr_ptr_q] <= wr_data;
		rd_q <= trade_mem[rd_ptr_q];
	end

	assign res_valid      = (state_q == S_STAT) || (state_q == S_SHOW);
	assign kind           = (state_q == S_SHOW);
	assign status         = (state_q == S_SHOW) ? ST_OK : status_q;
	assign bid_order_id   = kind ? rd_q.bid_id : 32'd0;
	assign ask_order_id   = kind ? rd_q.ask_id : 32'd0;
	assign trade_price    = kind ? rd_q.px : 32'd0;
	assign trade_quantity = kind ? rd_q.qty : 32'd0;
	assign best_bid       = head_b.valid ? head_b.price : 32'd0;
	assign best_ask       = head_a.valid ? head_a.price : 32'hFFFF_FFFF;
	assign resting_count  = count_q;
	assign last           = (state_q == S_STAT) || (rd_ptr_q == wr_ptr_q - IW'(1));

endmodule

// ===== hw/rtl/lobm_checker.sv =====
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on the order book matcher, bound to its top level.
// ----------------------------------------------------------------------------
module lobm_checker #(
	parameter int MAX_ORDERS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        kind,
	input logic [31:0] bid_order_id,
	input logic [31:0] trade_quantity,
	input logic [6:0]  resting_count,
	input logic        last
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("input taken while a command is in flight");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && last) |=> !res_valid)
		else $error("result beat after the final one");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !kind) |-> (last && bid_order_id == 32'd0 && trade_quantity == 32'd0))
		else $error("status result not alone or not clean");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		resting_count <= 7'(MAX_ORDERS))
		else $error("order count beyond capacity");

endmodule

bind limit_order_book_matcher_unit lobm_checker #(.MAX_ORDERS(MAX_ORDERS)) u_lobm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd_valid),
	.cmd_stall      (cmd_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.kind           (kind),
	.bid_order_id   (bid_order_id),
	.trade_quantity (trade_quantity),
	.resting_count  (resting_count),
	.last           (last)
);

// ===== dv/tb_limit_order_book_matcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_unit
// Self-checking bench for the order book matcher. A queue of commands feeds
// a clocked driver. A clocked monitor keeps its own copy of the book, works
// out the result beats of each accepted command, and compares every result
// beat field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher_unit;
	import lobm_pkg::*;

	localparam int BOOK_DEPTH = 64;
	localparam int RANDOM_TARGET = 370;
	localparam int CYCLE_LIMIT = 1000000;

	// One command as it is offered on the command channel. A command marked
	// hold_for_drain is not offered until every predicted beat has arrived.
	typedef struct {
		logic [1:0]  command;
		logic [31:0] order_id;
		logic        is_buy;
		logic [31:0] price;
		logic [31:0] quantity;
		bit          hold_for_drain;
	} book_cmd_t;

	// One result beat.
	typedef struct {
		logic        kind;
		logic [1:0]  status;
		logic [31:0] bid_order_id;
		logic [31:0] ask_order_id;
		logic [31:0] trade_price;
		logic [31:0] trade_quantity;
		logic [31:0] best_bid;
		logic [31:0] best_ask;
		logic [6:0]  resting_count;
		logic        last;
	} book_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  command = CMD_MATCH;
	logic [31:0] order_id = '0;
	logic        is_buy = 1'b0;
	logic [31:0] price = '0;
	logic [31:0] quantity = '0;
	logic        res_valid;
	logic        res_stall = 1'b1;
	logic        kind;
	logic [1:0]  status;
	logic [31:0] bid_order_id;
	logic [31:0] ask_order_id;
	logic [31:0] trade_price;
	logic [31:0] trade_quantity;
	logic [31:0] best_bid;
	logic [31:0] best_ask;
	logic [6:0]  resting_count;
	logic        last;

	limit_order_book_matcher_unit #(.MAX_ORDERS(BOOK_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.command(command), .order_id(order_id), .is_buy(is_buy),
		.price(price), .quantity(quantity),
		.res_valid(res_valid), .res_stall(res_stall),
		.kind(kind), .status(status),
		.bid_order_id(bid_order_id), .ask_order_id(ask_order_id),
		.trade_price(trade_price), .trade_quantity(trade_quantity),
		.best_bid(best_bid), .best_ask(best_ask),
		.resting_count(resting_count), .last(last)
	);

	// Commands still to be offered, and result beats predicted but not yet seen.
	book_cmd_t  cmd_backlog[$];
	book_beat_t predicted_beats[$];

	int total_cmds = 0;
	int cmds_accepted = 0;
	int beats_seen = 0;
	int trades_seen = 0;
	int mismatches = 0;
	int status_hits[4] = '{0, 0, 0, 0};
	int cycle_count = 0;
	bit cmd_beat_taken = 1'b0;

	// The bench's own copy of the book: one entry per slot.
	bit          slot_live[BOOK_DEPTH];
	bit          slot_is_bid[BOOK_DEPTH];
	logic [31:0] slot_order[BOOK_DEPTH];
	logic [31:0] slot_limit[BOOK_DEPTH];
	logic [31:0] slot_open_qty[BOOK_DEPTH];
	logic [31:0] slot_stamp[BOOK_DEPTH];
	logic [31:0] stamp_counter = '0;

	// Clock with a period of 8 ns.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Stamps compare in serial-number order, so the counter may wrap.
	function automatic bit stamped_earlier(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return d != 0 && !d[31];
	endfunction

	function automatic int slot_of_order(logic [31:0] id);
		for (int i = 0; i < BOOK_DEPTH; i++)
			if (slot_live[i] && slot_order[i] == id)
				return i;
		return -1;
	endfunction

	// Top of book on one side: best price first, then earliest stamp.
	function automatic int top_of_side(bit bid_side);
		int top;
		top = -1;
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			if (!slot_live[i] || slot_is_bid[i] != bid_side)
				continue;
			if (top < 0)
				top = i;
			else if (slot_limit[i] != slot_limit[top]) begin
				if (bid_side ? slot_limit[i] > slot_limit[top] : slot_limit[i] < slot_limit[top])
					top = i;
			end else if (stamped_earlier(slot_stamp[i], slot_stamp[top]))
				top = i;
		end
		return top;
	endfunction

	// Applies one accepted command to the bench's book and queues the beats
	// that it must produce. Book prices and count are those after the command.
	task automatic apply_book_cmd(input book_cmd_t c);
		book_beat_t fills[$];
		book_beat_t b;
		logic [1:0] st;
		logic [31:0] q;
		int s, bi, ai, live;
		st = ST_OK;
		b = '{default: '0};
		case (c.command)
			CMD_ADD: begin
				if (slot_of_order(c.order_id) >= 0)
					st = ST_DUP;
				else begin
					s = -1;
					for (int i = 0; i < BOOK_DEPTH; i++)
						if (!slot_live[i] && s < 0)
							s = i;
					if (s < 0)
						st = ST_FULL;
					else begin
						slot_live[s] = 1'b1;
						slot_is_bid[s] = c.is_buy;
						slot_order[s] = c.order_id;
						slot_limit[s] = c.price;
						slot_open_qty[s] = c.quantity;
						slot_stamp[s] = stamp_counter;
						stamp_counter = stamp_counter + 32'd1;
					end
				end
			end
			CMD_CANCEL, CMD_MODIFY: begin
				s = slot_of_order(c.order_id);
				if (s < 0)
					st = ST_NOT_FOUND;
				else if (c.command == CMD_CANCEL || c.quantity == 0)
					slot_live[s] = 1'b0;
				else
					slot_open_qty[s] = c.quantity;
			end
			default: begin
				// Cross the book until the spread opens; each trade retires at
				// least one order, so the loop ends within the book depth.
				while (1) begin
					bi = top_of_side(1'b1);
					ai = top_of_side(1'b0);
					if (bi < 0 || ai < 0 || slot_limit[bi] < slot_limit[ai])
						break;
					q = slot_open_qty[bi] < slot_open_qty[ai] ? slot_open_qty[bi]
							: slot_open_qty[ai];
					b = '{default: '0};
					b.kind = 1'b1;
					b.bid_order_id = slot_order[bi];
					b.ask_order_id = slot_order[ai];
					b.trade_price = slot_limit[ai];
					b.trade_quantity = q;
					fills.insert(fills.size(), b);
					slot_open_qty[bi] -= q;
					slot_open_qty[ai] -= q;
					if (slot_open_qty[bi] == 0)
						slot_live[bi] = 1'b0;
					if (slot_open_qty[ai] == 0)
						slot_live[ai] = 1'b0;
				end
			end
		endcase
		if (fills.size() == 0) begin
			b = '{default: '0};
			b.status = st;
			fills.insert(fills.size(), b);
		end
		bi = top_of_side(1'b1);
		ai = top_of_side(1'b0);
		live = 0;
		for (int i = 0; i < BOOK_DEPTH; i++)
			live += slot_live[i];
		foreach (fills[k]) begin
			fills[k].best_bid = bi >= 0 ? slot_limit[bi] : 32'd0;
			fills[k].best_ask = ai >= 0 ? slot_limit[ai] : 32'hFFFF_FFFF;
			fills[k].resting_count = live[6:0];
			fills[k].last = (k == fills.size() - 1);
			predicted_beats.insert(predicted_beats.size(), fills[k]);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	function automatic void queue_cmd(logic [1:0] cmd, logic [31:0] id, logic buy,
			logic [31:0] px, logic [31:0] qty, bit drain = 1'b0);
		book_cmd_t c;
		c = '{cmd, id, buy, px, qty, drain};
		cmd_backlog.insert(cmd_backlog.size(), c);
		total_cmds++;
	endfunction

	// Idle rates per phase: sender 37 / receiver 78, then swapped, then none.
	function automatic int sender_idle_pct();
		if (cmds_accepted < total_cmds / 3)
			return 37;
		if (cmds_accepted < 2 * total_cmds / 3)
			return 78;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (cmds_accepted < total_cmds / 3)
			return 78;
		if (cmds_accepted < 2 * total_cmds / 3)
			return 37;
		return 0;
	endfunction

	// Driver: a new command is presented at the falling edge only once the
	// previous beat was taken, so a stalled payload never changes.
	always @(negedge clk) begin
		if (arst_n) begin
			res_stall <= ($urandom_range(99) < receiver_idle_pct());
			if (!cmd_valid || cmd_beat_taken) begin
				if (cmd_backlog.size() != 0
						&& !(cmd_backlog[0].hold_for_drain && predicted_beats.size() != 0)
						&& $urandom_range(99) >= sender_idle_pct()) begin
					command <= cmd_backlog[0].command;
					order_id <= cmd_backlog[0].order_id;
					is_buy <= cmd_backlog[0].is_buy;
					price <= cmd_backlog[0].price;
					quantity <= cmd_backlog[0].quantity;
					cmd_backlog.delete(0);
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on every accepted command beat and checks every
	// accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		book_cmd_t  c;
		book_beat_t want;
		cmd_beat_taken = 1'b0;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				c = '{command, order_id, is_buy, price, quantity, 1'b0};
				apply_book_cmd(c);
				cmds_accepted++;
				cmd_beat_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				beats_seen++;
				if (predicted_beats.size() == 0) begin
					$error("result beat arrived with no prediction waiting");
					mismatches++;
				end else begin
					want = predicted_beats[0];
					predicted_beats.delete(0);
					if (want.kind)
						trades_seen++;
					else
						status_hits[want.status]++;
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("status", 32'(want.status), 32'(status));
					check_field("bid_order_id", want.bid_order_id, bid_order_id);
					check_field("ask_order_id", want.ask_order_id, ask_order_id);
					check_field("trade_price", want.trade_price, trade_price);
					check_field("trade_quantity", want.trade_quantity, trade_quantity);
					check_field("best_bid", want.best_bid, best_bid);
					check_field("best_ask", want.best_ask, best_ask);
					check_field("resting_count", 32'(want.resting_count),
							32'(resting_count));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_limit_order_book_matcher_unit: FAIL");
			$finish;
		end
	end

	initial begin
		int pick;
		logic [31:0] id, px, qty;
		foreach (slot_live[i])
			slot_live[i] = 1'b0;

		// Directed part: extreme ids, prices and quantities, duplicate add,
		// unknown ids, modify in place, modify to zero, zero-quantity orders,
		// time priority at one price, and matches with and without trades.
		queue_cmd(CMD_ADD, 32'd0, 1'b1, 32'd100, 32'd10);
		queue_cmd(CMD_ADD, 32'hFFFF_FFFF, 1'b0, 32'd100, 32'd4);
		queue_cmd(CMD_ADD, 32'd0, 1'b0, 32'd5, 32'd1);
		queue_cmd(CMD_ADD, 32'd7, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(CMD_ADD, 32'd8, 1'b1, 32'd0, 32'd0);
		queue_cmd(CMD_ADD, 32'd9, 1'b1, 32'd100, 32'd3);
		queue_cmd(CMD_CANCEL, 32'd12345, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_MODIFY, 32'd777, 1'b0, 32'd0, 32'd5);
		queue_cmd(CMD_MODIFY, 32'd9, 1'b0, 32'd0, 32'd6);
		queue_cmd(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_ADD, 32'd10, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_MODIFY, 32'd7, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_CANCEL, 32'd8, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_ADD, 32'd11, 1'b0, 32'd50, 32'd100);
		queue_cmd(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_CANCEL, 32'd11, 1'b0, 32'd0, 32'd0);

		// Fill the book to the brim with bids, overflow it, then free one
		// slot for a deep ask that sweeps every bid in one long match.
		for (int k = 0; k < BOOK_DEPTH + 2; k++)
			queue_cmd(CMD_ADD, 32'd2000 + k, 1'b1, 32'd1000 + (k % 3),
					$urandom_range(1, 20), k == 0);
		queue_cmd(CMD_ADD, 32'd3000, 1'b0, 32'd1, 32'hFFFF_FFFF);
		queue_cmd(CMD_CANCEL, 32'd2000, 1'b1, 32'd0, 32'd0);
		queue_cmd(CMD_ADD, 32'd3000, 1'b0, 32'd1, 32'hFFFF_FFFF);
		queue_cmd(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'd0);
		queue_cmd(CMD_CANCEL, 32'd3000, 1'b0, 32'd0, 32'd0);

		// Random part: ids mostly from a small pool so that cancels, modifies
		// and duplicates hit live orders; prices near one level so books cross.
		while (total_cmds < RANDOM_TARGET) begin
			pick = $urandom_range(99);
			id = ($urandom_range(99) < 85) ? 32'($urandom_range(1, 48)) : $urandom;
			px = ($urandom_range(99) < 85) ? 32'($urandom_range(95, 105)) : $urandom;
			qty = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 50)) : $urandom;
			if (pick < 45)
				queue_cmd(CMD_ADD, id, 1'($urandom_range(1)), px, qty);
			else if (pick < 60)
				queue_cmd(CMD_CANCEL, id, 1'($urandom_range(1)), $urandom, $urandom);
			else if (pick < 75)
				queue_cmd(CMD_MODIFY, id, 1'($urandom_range(1)), $urandom, qty);
			else
				queue_cmd(CMD_MATCH, $urandom, 1'($urandom_range(1)), $urandom, $urandom);
		end

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every command to be taken and every beat to arrive, then
		// give the block time to show any stray beat.
		while (cmd_backlog.size() != 0 || cmd_valid || predicted_beats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d commands, %0d result beats: %0d trades, %0d ok, %0d unknown id,",
				cmds_accepted, beats_seen, trades_seen, status_hits[ST_OK],
				status_hits[ST_NOT_FOUND]);
		$display("%0d rejected full, %0d rejected duplicate, %0d mismatches",
				status_hits[ST_FULL], status_hits[ST_DUP], mismatches);
		if (mismatches == 0 && predicted_beats.size() == 0)
			$display("tb_limit_order_book_matcher_unit: PASS");
		else
			$display("tb_limit_order_book_matcher_unit: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_cell.sv
hw/rtl/lobm_chain.sv
hw/rtl/limit_order_book_matcher_unit.sv
hw/rtl/lobm_checker.sv
dv/tb_limit_order_book_matcher_unit.sv
